/* rtl/core/fema_pkg.sv */
// shared types, constants and command codes for the free extent map allocator
// no dependencies
package fema_pkg;

    localparam int MapEntries = 82;
    localparam int IdxW = 7;
    localparam int SectW = 24;
    localparam logic [SectW-1:0] SectMax = {SectW{1'b1}};

    typedef enum logic [2:0] {
        CMD_LOAD   = 3'd0,
        CMD_READ   = 3'd1,
        CMD_ALLOC  = 3'd2,
        CMD_FREE   = 3'd3,
        CMD_EXTEND = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_FULL     = 2'd2,
        ST_BAD_IDX  = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [6:0]  entry_index;
        logic [23:0] start_sector;
        logic [23:0] entry_sectors;
        logic [31:0] byte_count;
        logic [31:0] held_bytes;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [23:0] granted_sector;
        logic [23:0] read_start;
        logic [23:0] read_length;
        logic [6:0]  free_count;
        logic        map_changed;
    } out_item_t;

    // classified command handed from front to back
    typedef struct packed {
        logic [2:0]  command;
        logic [6:0]  entry_index;
        logic [23:0] start_sector;
        logic [23:0] entry_sectors;
        logic [24:0] reqd;      // sectors needed, bit 24 set means too big
        logic [24:0] target;    // extend target start, full width
    } work_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SCAN,
        BK_SHIFT_DN,
        BK_SHIFT_UP,
        BK_DONE
    } bk_state_t;

endpackage

/* rtl/core/fema_front.sv */
// front part: accepts commands, rounds sizes to sectors, queues the work
// depends on fema_pkg
module fema_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  fema_pkg::in_item_t s_data,
    output logic               w_valid,
    input  logic               w_ready,
    output fema_pkg::work_t    w_data
);

    fema_pkg::work_t q_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wp_reg, rp_reg;
    fema_pkg::work_t w;
    logic [32:0] rnd;
    logic [32:0] diff;
    logic push, pop;

    always_comb begin
        w = '0;
        w.command = s_data.command;
        w.entry_index = s_data.entry_index;
        w.start_sector = s_data.start_sector;
        w.entry_sectors = s_data.entry_sectors;
        diff = '0;
        if (s_data.command == fema_pkg::CMD_EXTEND) begin
            if (s_data.byte_count > s_data.held_bytes)
                diff = {1'b0, s_data.byte_count - s_data.held_bytes};
        end else begin
            diff = {1'b0, s_data.byte_count};
        end
        rnd = diff + 33'd255;
        w.reqd = rnd[32:8];
        if (s_data.command == fema_pkg::CMD_FREE && rnd[32])
            w.reqd = {1'b0, fema_pkg::SectMax};
        w.target = {1'b0, s_data.start_sector} + {1'b0, s_data.held_bytes[31:8]};
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign w_valid = (cnt_reg != 2'd0);
    assign w_data  = q_reg[rp_reg];
    assign push = s_valid && s_ready;
    assign pop  = w_valid && w_ready;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) cnt_next = cnt_reg + 2'd1;
        else if (pop && !push) cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (push) q_reg[wp_reg] <= w;
        if (!aresetn) begin
            cnt_reg <= '0;
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
        end
    end

endmodule

/* rtl/core/fema_back.sv */
// back part: extent table memory, sequential scan and shift engine
// depends on fema_pkg
module fema_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                w_valid,
    output logic                w_ready,
    input  fema_pkg::work_t     w_data,
    output logic                m_valid,
    input  logic                m_ready,
    output fema_pkg::out_item_t m_data,
    output logic [6:0]          count_out
);

    logic [47:0] mem [fema_pkg::MapEntries];
    logic [47:0] rd_reg;
    logic [6:0]  raddr;
    logic        wen;
    logic [6:0]  waddr;
    logic [47:0] wdata;

    fema_pkg::bk_state_t st_reg, st_next;
    fema_pkg::work_t     job_reg, job_next;
    logic [6:0] count_reg, count_next;
    logic [6:0] i_reg, i_next;
    logic       rdv_reg, rdv_next;
    logic       mv_reg, mv_next;
    fema_pkg::out_item_t res_reg, res_next;
    fema_pkg::out_item_t out_reg, out_next;

    logic [23:0] es, el;
    logic [24:0] endp;
    logic [24:0] msum;

    assign es = rd_reg[47:24];
    assign el = rd_reg[23:0];
    assign endp = {1'b0, es} + {1'b0, el};
    assign msum = {1'b0, el} + job_reg.reqd;
    assign w_ready = (st_reg == fema_pkg::BK_IDLE);
    assign m_valid = mv_reg;
    assign m_data = out_reg;
    assign count_out = count_reg;

    always_ff @(posedge aclk) begin
        if (wen) mem[waddr] <= wdata;
        rd_reg <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        job_reg <= job_next;
        res_reg <= res_next;
        out_reg <= out_next;
        i_reg <= i_next;
        if (!aresetn) begin
            st_reg <= fema_pkg::BK_IDLE;
            count_reg <= '0;
            rdv_reg <= 1'b0;
            mv_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            count_reg <= count_next;
            rdv_reg <= rdv_next;
            mv_reg <= mv_next;
        end
    end

    always_comb begin
        st_next = st_reg;
        job_next = job_reg;
        count_next = count_reg;
        i_next = i_reg;
        rdv_next = 1'b0;
        mv_next = mv_reg;
        res_next = res_reg;
        out_next = out_reg;
        raddr = i_reg;
        wen = 1'b0;
        waddr = i_reg;
        wdata = rd_reg;
        if (mv_reg && m_ready) mv_next = 1'b0;
        case (st_reg)
            fema_pkg::BK_IDLE: begin
                if (w_valid) begin
                    job_next = w_data;
                    res_next = '0;
                    i_next = '0;
                    raddr = '0;
                    rdv_next = 1'b1;
                    st_next = fema_pkg::BK_SCAN;
                    case (w_data.command)
                        fema_pkg::CMD_LOAD: begin
                            st_next = fema_pkg::BK_DONE;
                            if (w_data.entry_index < 7'(fema_pkg::MapEntries)) begin
                                wen = 1'b1;
                                waddr = w_data.entry_index;
                                wdata = {w_data.start_sector, w_data.entry_sectors};
                                count_next = w_data.entry_index + 7'd1;
                                res_next.map_changed = 1'b1;
                            end else begin
                                res_next.status = fema_pkg::ST_BAD_IDX;
                            end
                        end
                        fema_pkg::CMD_READ: begin
                            raddr = w_data.entry_index;
                            if (w_data.entry_index >= count_reg)
                                res_next.status = fema_pkg::ST_BAD_IDX;
                        end
                        fema_pkg::CMD_ALLOC, fema_pkg::CMD_EXTEND:
                            res_next.status = fema_pkg::ST_NO_SPACE;
                        fema_pkg::CMD_FREE: ;
                        default: st_next = fema_pkg::BK_DONE;
                    endcase
                end
            end
            fema_pkg::BK_SCAN: begin
                if (rdv_reg) begin
                    case (job_reg.command)
                        fema_pkg::CMD_READ: begin
                            if (res_reg.status == fema_pkg::ST_OK) begin
                                res_next.read_start = es;
                                res_next.read_length = el;
                            end
                            st_next = fema_pkg::BK_DONE;
                        end
                        default: begin
                            if (i_reg >= count_reg) begin
                                if (job_reg.command == fema_pkg::CMD_FREE) begin
                                    if (count_reg >= 7'(fema_pkg::MapEntries)) begin
                                        res_next.status = fema_pkg::ST_FULL;
                                        st_next = fema_pkg::BK_DONE;
                                    end else begin
                                        st_next = fema_pkg::BK_SHIFT_UP;
                                        job_next.entry_index = i_reg;
                                        i_next = count_reg;
                                    end
                                end else begin
                                    st_next = fema_pkg::BK_DONE;
                                end
                            end else if (job_reg.command == fema_pkg::CMD_FREE) begin
                                if (endp == {1'b0, job_reg.start_sector}) begin
                                    wen = 1'b1;
                                    wdata = {es, msum[24] ? fema_pkg::SectMax : msum[23:0]};
                                    res_next.map_changed = 1'b1;
                                    st_next = fema_pkg::BK_DONE;
                                end else if (es > job_reg.start_sector) begin
                                    if (count_reg >= 7'(fema_pkg::MapEntries)) begin
                                        res_next.status = fema_pkg::ST_FULL;
                                        st_next = fema_pkg::BK_DONE;
                                    end else begin
                                        st_next = fema_pkg::BK_SHIFT_UP;
                                        job_next.entry_index = i_reg;
                                        i_next = count_reg;
                                    end
                                end else begin
                                    i_next = i_reg + 7'd1;
                                    raddr = i_next;
                                    rdv_next = 1'b1;
                                end
                            end else begin
                                if ((job_reg.command == fema_pkg::CMD_ALLOC
                                     && {1'b0, el} >= job_reg.reqd)
                                    || (job_reg.command == fema_pkg::CMD_EXTEND
                                     && {1'b0, es} == job_reg.target)) begin
                                    st_next = fema_pkg::BK_DONE;
                                    if ({1'b0, el} >= job_reg.reqd) begin
                                        res_next.status = fema_pkg::ST_OK;
                                        res_next.map_changed = 1'b1;
                                        if (job_reg.command == fema_pkg::CMD_ALLOC)
                                            res_next.granted_sector = es;
                                        if ({1'b0, el} == job_reg.reqd) begin
                                            st_next = fema_pkg::BK_SHIFT_DN;
                                            i_next = i_reg + 7'd1;
                                            raddr = i_next;
                                            rdv_next = 1'b1;
                                        end else begin
                                            wen = 1'b1;
                                            wdata = {es + job_reg.reqd[23:0],
                                                     el - job_reg.reqd[23:0]};
                                        end
                                    end
                                end else begin
                                    i_next = i_reg + 7'd1;
                                    raddr = i_next;
                                    rdv_next = 1'b1;
                                end
                            end
                        end
                    endcase
                end
            end
            fema_pkg::BK_SHIFT_DN: begin
                if (rdv_reg) begin
                    if (i_reg >= count_reg) begin
                        count_next = count_reg - 7'd1;
                        st_next = fema_pkg::BK_DONE;
                    end else begin
                        wen = 1'b1;
                        waddr = i_reg - 7'd1;
                        i_next = i_reg + 7'd1;
                        raddr = i_next;
                        rdv_next = 1'b1;
                    end
                end
            end
            fema_pkg::BK_SHIFT_UP: begin
                if (i_reg == job_reg.entry_index) begin
                    wen = 1'b1;
                    waddr = i_reg;
                    wdata = {job_reg.start_sector, job_reg.reqd[23:0]};
                    count_next = count_reg + 7'd1;
                    res_next.map_changed = 1'b1;
                    st_next = fema_pkg::BK_DONE;
                end else if (!rdv_reg) begin
                    raddr = i_reg - 7'd1;
                    rdv_next = 1'b1;
                end else begin
                    wen = 1'b1;
                    waddr = i_reg;
                    i_next = i_reg - 7'd1;
                end
            end
            fema_pkg::BK_DONE: begin
                if (!mv_reg || m_ready) begin
                    out_next = res_reg;
                    out_next.free_count = count_reg;
                    mv_next = 1'b1;
                    st_next = fema_pkg::BK_IDLE;
                end
            end
            default: st_next = fema_pkg::BK_IDLE;
        endcase
    end

endmodule

/* rtl/core/free_extent_map_allocator_unit.sv */
// top level of the free extent map allocator
// depends on fema_pkg, fema_front, fema_back
// One command per transfer, one result per command. Load, read and unknown
// codes need no table walk; allocate, free and extend walk the table one
// entry per cycle through the single read port of the extent memory, then
// shift entries: down one per cycle, or up by reading and then writing each.
// A two-entry queue lets new commands be taken while the back end works.
module free_extent_map_allocator_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  fema_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output fema_pkg::out_item_t m_data
);

    logic            w_valid, w_ready;
    fema_pkg::work_t w_data;
    logic [6:0]      count;

    fema_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data,
        .w_valid, .w_ready, .w_data
    );

    fema_back u_back (
        .aclk, .aresetn, .w_valid, .w_ready, .w_data,
        .m_valid, .m_ready, .m_data, .count_out(count)
    );

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count <= 7'(fema_pkg::MapEntries)) else $error("extent count overflow");

    a_fail_no_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != fema_pkg::ST_OK |-> m_data.granted_sector == '0
        && !m_data.map_changed) else $error("failed command changed map");

    a_count_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !$past(m_valid) |-> m_data.free_count == count)
        else $error("free count mismatch");

endmodule
